// File: rtl/dcm_pkg.sv
// Shared types, constants and helpers for the drive command mode and slew limiter.
package dcm_pkg;

    localparam int VELOCITY_BITS_DEFAULT = 16;
    localparam int SAT_W                 = 40;   // headroom for products and slew sums
    localparam int FIELD_W               = 16;
    localparam int STEP_W                = 15;
    localparam int APB_ADDR_W            = 5;
    localparam int APB_DATA_W            = 32;

    typedef enum logic [1:0] {
        OP_JOY    = 2'd0,
        OP_AUTO   = 2'd1,
        OP_STATUS = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_GAIN_LIN_NORMAL = 3'd0,
        REG_GAIN_LIN_TURBO  = 3'd1,
        REG_GAIN_ANG_NORMAL = 3'd2,
        REG_GAIN_ANG_TURBO  = 3'd3,
        REG_AUTO_LIN_GAIN   = 3'd4,
        REG_AUTO_ANG_GAIN   = 3'd5,
        REG_SLEW_STEP       = 3'd6,
        REG_ZERO_BAND       = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [FIELD_W-1:0] gain_linear_normal;
        logic [FIELD_W-1:0] gain_linear_turbo;
        logic [FIELD_W-1:0] gain_angular_normal;
        logic [FIELD_W-1:0] gain_angular_turbo;
        logic [FIELD_W-1:0] auto_linear_gain;
        logic [FIELD_W-1:0] auto_angular_gain;
        logic [STEP_W-1:0]  slew_step;
        logic [STEP_W-1:0]  zero_band;
    } cfg_t;

    // Clamp to a signed range of the given width; result stays SAT_W wide.
    function automatic logic signed [SAT_W-1:0] sat_vel(
        input logic signed [SAT_W-1:0] v,
        input int                      bits
    );
        logic signed [SAT_W-1:0] one;
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        one = SAT_W'(1);
        hi  = (one <<< (bits - 1)) - one;
        lo  = -hi - one;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

// File: rtl/dcm_cfg_regs.sv
// APB configuration register file for the drive command block.
module dcm_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dcm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dcm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dcm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output dcm_pkg::cfg_t                     cfg
);
    import dcm_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (index)
                REG_GAIN_LIN_NORMAL: cfg_next.gain_linear_normal  = pwdata[FIELD_W-1:0];
                REG_GAIN_LIN_TURBO:  cfg_next.gain_linear_turbo   = pwdata[FIELD_W-1:0];
                REG_GAIN_ANG_NORMAL: cfg_next.gain_angular_normal = pwdata[FIELD_W-1:0];
                REG_GAIN_ANG_TURBO:  cfg_next.gain_angular_turbo  = pwdata[FIELD_W-1:0];
                REG_AUTO_LIN_GAIN:   cfg_next.auto_linear_gain    = pwdata[FIELD_W-1:0];
                REG_AUTO_ANG_GAIN:   cfg_next.auto_angular_gain   = pwdata[FIELD_W-1:0];
                REG_SLEW_STEP:       cfg_next.slew_step           = pwdata[STEP_W-1:0];
                REG_ZERO_BAND:       cfg_next.zero_band           = pwdata[STEP_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (index)
            REG_GAIN_LIN_NORMAL: prdata = APB_DATA_W'(cfg_reg.gain_linear_normal);
            REG_GAIN_LIN_TURBO:  prdata = APB_DATA_W'(cfg_reg.gain_linear_turbo);
            REG_GAIN_ANG_NORMAL: prdata = APB_DATA_W'(cfg_reg.gain_angular_normal);
            REG_GAIN_ANG_TURBO:  prdata = APB_DATA_W'(cfg_reg.gain_angular_turbo);
            REG_AUTO_LIN_GAIN:   prdata = APB_DATA_W'(cfg_reg.auto_linear_gain);
            REG_AUTO_ANG_GAIN:   prdata = APB_DATA_W'(cfg_reg.auto_angular_gain);
            REG_SLEW_STEP:       prdata = APB_DATA_W'(cfg_reg.slew_step);
            REG_ZERO_BAND:       prdata = APB_DATA_W'(cfg_reg.zero_band);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_linear_normal  <= FIELD_W'(4096);
            cfg_reg.gain_linear_turbo   <= FIELD_W'(8192);
            cfg_reg.gain_angular_normal <= FIELD_W'(4096);
            cfg_reg.gain_angular_turbo  <= FIELD_W'(8192);
            cfg_reg.auto_linear_gain    <= FIELD_W'(4096);
            cfg_reg.auto_angular_gain   <= FIELD_W'(4096);
            cfg_reg.slew_step           <= STEP_W'(41);
            cfg_reg.zero_band           <= STEP_W'(41);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/dcm_scale.sv
// One channel of target scaling: stick or autonomous value times gain, floor shift, clamp.
module dcm_scale #(
    parameter int VELOCITY_BITS = dcm_pkg::VELOCITY_BITS_DEFAULT
) (
    input  logic                                 sel_auto,
    input  logic signed [dcm_pkg::FIELD_W-1:0]   stick,
    input  logic        [dcm_pkg::FIELD_W-1:0]   stick_gain,
    input  logic signed [dcm_pkg::FIELD_W-1:0]   auto_val,
    input  logic        [dcm_pkg::FIELD_W-1:0]   auto_gain,
    output logic signed [VELOCITY_BITS-1:0]      result
);
    import dcm_pkg::*;

    localparam int PROD_W = 2 * FIELD_W + 1;

    logic signed [FIELD_W-1:0] val;
    logic signed [FIELD_W:0]   gain_s;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  shifted;
    logic signed [SAT_W-1:0]   wide;
    logic signed [SAT_W-1:0]   clamped;

    // stick is Q1.15, autonomous request Q4.12; gains are Q4.12
    assign val     = sel_auto ? auto_val : stick;
    assign gain_s  = signed'({1'b0, (sel_auto ? auto_gain : stick_gain)});
    assign prod    = val * gain_s;
    assign shifted = sel_auto ? (prod >>> 12) : (prod >>> 15);
    assign wide    = {{(SAT_W-PROD_W){shifted[PROD_W-1]}}, shifted};
    assign clamped = sat_vel(wide, VELOCITY_BITS);
    assign result  = clamped[VELOCITY_BITS-1:0];

endmodule

// File: rtl/dcm_slew.sv
// One channel of the slew limiter: take target within one limit, else step by one or two limits, clamp.
module dcm_slew #(
    parameter int VELOCITY_BITS = dcm_pkg::VELOCITY_BITS_DEFAULT
) (
    input  logic signed [VELOCITY_BITS-1:0]    target,
    input  logic signed [VELOCITY_BITS-1:0]    last,
    input  logic        [dcm_pkg::STEP_W-1:0]  step,
    output logic signed [VELOCITY_BITS-1:0]    cmd
);
    import dcm_pkg::*;

    logic signed [SAT_W-1:0] t_w;
    logic signed [SAT_W-1:0] l_w;
    logic signed [SAT_W-1:0] lim;
    logic signed [SAT_W-1:0] lim2;
    logic signed [SAT_W-1:0] lim5;
    logic signed [SAT_W-1:0] d;
    logic signed [SAT_W-1:0] r;
    logic signed [SAT_W-1:0] clamped;

    assign t_w  = {{(SAT_W-VELOCITY_BITS){target[VELOCITY_BITS-1]}}, target};
    assign l_w  = {{(SAT_W-VELOCITY_BITS){last[VELOCITY_BITS-1]}}, last};
    assign lim  = signed'({{(SAT_W-STEP_W){1'b0}}, step});
    assign lim2 = lim <<< 1;
    assign lim5 = (lim <<< 2) + lim;
    assign d    = t_w - l_w;

    always_comb begin
        r = t_w;
        if (d > lim) begin
            r = (d > lim5) ? l_w + lim2 : l_w + lim;
        end else if (d < -lim) begin
            r = (d < -lim5) ? l_w - lim2 : l_w - lim;
        end
    end

    assign clamped = sat_vel(r, VELOCITY_BITS);
    assign cmd     = clamped[VELOCITY_BITS-1:0];

endmodule

// File: rtl/drive_command_mode_and_slew_limiter.sv
// Top level: event register, mode/stop state, target scaling, slew limiting, result register.
//
//  channel  direction  handshake          payload
//  -------  ---------  -----------------  ---------------------------------------------
//  s_       in         s_valid / s_ready  operation, buttons, stick axes, auto request,
//                                         localization status
//  m_       out        m_valid / m_ready  linear/angular command, auto/turbo/stop flags
//  apb      in         psel/penable/...   eight config registers at 4*i, pready tied high
//
//  Path: an s_ transaction reaches m_ through the event register, then the result register.
//  One transaction per cycle sustained unless a tick stalls; joystick, auto and status
//  events produce no result, a tick produces one.
//  Critical path: the 16x17 multiply in dcm_scale feeding the target registers, and the
//  slew subtract/compare/add feeding last and the result register.
//  Stall: a tick in the event register waits only while the result register is full and
//  m_ready is low; other events drain regardless.
//  Reset (aresetn, synchronous): all mode flags, targets and last commands clear, config
//  registers load their defaults.
module drive_command_mode_and_slew_limiter #(
    parameter int VELOCITY_BITS = dcm_pkg::VELOCITY_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB config
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dcm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [dcm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [dcm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // input events
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic                                s_gear_pressed,
    input  logic                                s_enable_pressed,
    input  logic signed [dcm_pkg::FIELD_W-1:0]  s_stick_linear,
    input  logic                                s_stick_linear_present,
    input  logic signed [dcm_pkg::FIELD_W-1:0]  s_stick_angular,
    input  logic                                s_stick_angular_present,
    input  logic signed [dcm_pkg::FIELD_W-1:0]  s_auto_linear,
    input  logic signed [dcm_pkg::FIELD_W-1:0]  s_auto_angular,
    input  logic                                s_status_ok,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [dcm_pkg::FIELD_W-1:0]  m_linear_cmd,
    output logic signed [dcm_pkg::FIELD_W-1:0]  m_angular_cmd,
    output logic                                m_auto_engaged,
    output logic                                m_turbo_engaged,
    output logic                                m_stop_active
);
    import dcm_pkg::*;

    localparam int VB = VELOCITY_BITS;

    cfg_t cfg;

    // event register
    logic                      in_valid_reg, in_valid_next;
    op_t                       in_op_reg;
    logic                      in_gear_reg;
    logic                      in_enable_reg;
    logic signed [FIELD_W-1:0] in_stick_lin_reg;
    logic                      in_stick_lin_pres_reg;
    logic signed [FIELD_W-1:0] in_stick_ang_reg;
    logic                      in_stick_ang_pres_reg;
    logic signed [FIELD_W-1:0] in_auto_lin_reg;
    logic signed [FIELD_W-1:0] in_auto_ang_reg;
    logic                      in_status_ok_reg;

    // mode / stop state
    logic turbo_mode_reg,     turbo_mode_next;
    logic gear_latch_reg,     gear_latch_next;
    logic auto_flag_reg,      auto_flag_next;
    logic localized_flag_reg, localized_flag_next;
    logic stop_pending_reg,   stop_pending_next;
    logic resume_auto_reg,    resume_auto_next;
    logic stop_armed_reg,     stop_armed_next;

    logic signed [VB-1:0] target_lin_reg, target_lin_next;
    logic signed [VB-1:0] target_ang_reg, target_ang_next;
    logic signed [VB-1:0] last_lin_reg,   last_lin_next;
    logic signed [VB-1:0] last_ang_reg,   last_ang_next;

    // result register
    logic                      m_valid_reg, m_valid_next;
    logic signed [FIELD_W-1:0] m_lin_reg;
    logic signed [FIELD_W-1:0] m_ang_reg;
    logic                      m_auto_reg;
    logic                      m_turbo_reg;
    logic                      m_stop_reg;

    logic s_fire;
    logic proc_fire;
    logic is_tick;
    logic in_stall;
    logic out_load;

    logic                 sel_auto;
    logic [FIELD_W-1:0]   lin_stick_gain;
    logic [FIELD_W-1:0]   ang_stick_gain;
    logic signed [VB-1:0] scaled_lin;
    logic signed [VB-1:0] scaled_ang;

    logic signed [SAT_W-1:0] zb_w;
    logic signed [SAT_W-1:0] tl_w;
    logic signed [SAT_W-1:0] ta_w;
    logic                    inside_band;
    logic                    stop_hold;
    logic signed [VB-1:0]    tick_tgt_lin;
    logic signed [VB-1:0]    tick_tgt_ang;
    logic signed [VB-1:0]    slew_lin;
    logic signed [VB-1:0]    slew_ang;
    logic signed [SAT_W-1:0] slew_lin_w;
    logic signed [SAT_W-1:0] slew_ang_w;

    dcm_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- handshake ----------------
    assign is_tick   = (in_op_reg == OP_TICK);
    // only a tick needs the result slot
    assign in_stall  = in_valid_reg && is_tick && m_valid_reg && !m_ready;
    assign s_ready   = !in_stall;
    assign s_fire    = s_valid && s_ready;
    assign proc_fire = in_valid_reg && !in_stall;
    assign out_load  = proc_fire && is_tick;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------- gear edge (feeds gain select) ----------------
    always_comb begin
        turbo_mode_next = turbo_mode_reg;
        gear_latch_next = gear_latch_reg;
        if (proc_fire && in_op_reg == OP_JOY) begin
            if (in_gear_reg && !gear_latch_reg) begin
                turbo_mode_next = !turbo_mode_reg;
                gear_latch_next = 1'b1;
            end else if (!in_gear_reg && gear_latch_reg) begin
                gear_latch_next = 1'b0;
            end
        end
    end

    // ---------------- scaling ----------------
    // gain follows the mode after this report's toggle
    assign sel_auto       = (in_op_reg == OP_AUTO);
    assign lin_stick_gain = turbo_mode_next ? cfg.gain_linear_turbo  : cfg.gain_linear_normal;
    assign ang_stick_gain = turbo_mode_next ? cfg.gain_angular_turbo : cfg.gain_angular_normal;

    dcm_scale #(.VELOCITY_BITS(VB)) u_scale_lin (
        .sel_auto   (sel_auto),
        .stick      (in_stick_lin_reg),
        .stick_gain (lin_stick_gain),
        .auto_val   (in_auto_lin_reg),
        .auto_gain  (cfg.auto_linear_gain),
        .result     (scaled_lin)
    );

    dcm_scale #(.VELOCITY_BITS(VB)) u_scale_ang (
        .sel_auto   (sel_auto),
        .stick      (in_stick_ang_reg),
        .stick_gain (ang_stick_gain),
        .auto_val   (in_auto_ang_reg),
        .auto_gain  (cfg.auto_angular_gain),
        .result     (scaled_ang)
    );

    // ---------------- tick: stop check then slew ----------------
    assign zb_w = signed'({{(SAT_W-STEP_W){1'b0}}, cfg.zero_band});
    assign tl_w = {{(SAT_W-VB){target_lin_reg[VB-1]}}, target_lin_reg};
    assign ta_w = {{(SAT_W-VB){target_ang_reg[VB-1]}}, target_ang_reg};
    assign inside_band = (tl_w < zb_w) && (tl_w > -zb_w) && (ta_w < zb_w) && (ta_w > -zb_w);
    // pending stop holds targets at zero until both are already near zero
    assign stop_hold    = stop_pending_reg && !inside_band;
    assign tick_tgt_lin = stop_hold ? '0 : target_lin_reg;
    assign tick_tgt_ang = stop_hold ? '0 : target_ang_reg;

    dcm_slew #(.VELOCITY_BITS(VB)) u_slew_lin (
        .target (tick_tgt_lin),
        .last   (last_lin_reg),
        .step   (cfg.slew_step),
        .cmd    (slew_lin)
    );

    dcm_slew #(.VELOCITY_BITS(VB)) u_slew_ang (
        .target (tick_tgt_ang),
        .last   (last_ang_reg),
        .step   (cfg.slew_step),
        .cmd    (slew_ang)
    );

    assign slew_lin_w = {{(SAT_W-VB){slew_lin[VB-1]}}, slew_lin};
    assign slew_ang_w = {{(SAT_W-VB){slew_ang[VB-1]}}, slew_ang};

    // ---------------- event update ----------------
    always_comb begin
        auto_flag_next      = auto_flag_reg;
        localized_flag_next = localized_flag_reg;
        stop_pending_next   = stop_pending_reg;
        resume_auto_next    = resume_auto_reg;
        stop_armed_next     = stop_armed_reg;
        target_lin_next     = target_lin_reg;
        target_ang_next     = target_ang_reg;
        last_lin_next       = last_lin_reg;
        last_ang_next       = last_ang_reg;
        if (proc_fire) begin
            case (in_op_reg)
                OP_JOY: begin
                    if (!in_enable_reg || !localized_flag_reg) begin
                        auto_flag_next  = 1'b0;
                        target_lin_next = in_stick_lin_pres_reg ? scaled_lin : '0;
                        target_ang_next = in_stick_ang_pres_reg ? scaled_ang : '0;
                    end else begin
                        auto_flag_next = 1'b1;
                    end
                end
                OP_AUTO: begin
                    if (auto_flag_reg) begin
                        target_lin_next = scaled_lin;
                        target_ang_next = scaled_ang;
                    end
                end
                OP_STATUS: begin
                    if (in_status_ok_reg) begin
                        localized_flag_next = 1'b1;
                        stop_pending_next   = 1'b0;
                        stop_armed_next     = 1'b0;
                        if (resume_auto_reg) begin
                            auto_flag_next   = 1'b1;
                            resume_auto_next = 1'b0;
                        end
                    end else begin
                        localized_flag_next = 1'b0;
                        auto_flag_next      = 1'b0;
                        if (auto_flag_reg) begin
                            target_lin_next  = '0;
                            target_ang_next  = '0;
                            resume_auto_next = 1'b1;
                        end
                        // one-shot: a second loss before regaining does not re-arm
                        if (!stop_armed_reg) begin
                            stop_pending_next = 1'b1;
                            stop_armed_next   = 1'b1;
                        end
                    end
                end
                OP_TICK: begin
                    stop_pending_next = stop_hold;
                    target_lin_next   = tick_tgt_lin;
                    target_ang_next   = tick_tgt_ang;
                    last_lin_next     = slew_lin;
                    last_ang_next     = slew_ang;
                end
                default: begin
                    auto_flag_next = auto_flag_reg;
                end
            endcase
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
            turbo_mode_reg     <= 1'b0;
            gear_latch_reg     <= 1'b0;
            auto_flag_reg      <= 1'b0;
            localized_flag_reg <= 1'b0;
            stop_pending_reg   <= 1'b0;
            resume_auto_reg    <= 1'b0;
            stop_armed_reg     <= 1'b0;
            target_lin_reg     <= '0;
            target_ang_reg     <= '0;
            last_lin_reg       <= '0;
            last_ang_reg       <= '0;
        end else begin
            in_valid_reg       <= in_valid_next;
            m_valid_reg        <= m_valid_next;
            turbo_mode_reg     <= turbo_mode_next;
            gear_latch_reg     <= gear_latch_next;
            auto_flag_reg      <= auto_flag_next;
            localized_flag_reg <= localized_flag_next;
            stop_pending_reg   <= stop_pending_next;
            resume_auto_reg    <= resume_auto_next;
            stop_armed_reg     <= stop_armed_next;
            target_lin_reg     <= target_lin_next;
            target_ang_reg     <= target_ang_next;
            last_lin_reg       <= last_lin_next;
            last_ang_reg       <= last_ang_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg             <= op_t'(s_operation);
            in_gear_reg           <= s_gear_pressed;
            in_enable_reg         <= s_enable_pressed;
            in_stick_lin_reg      <= s_stick_linear;
            in_stick_lin_pres_reg <= s_stick_linear_present;
            in_stick_ang_reg      <= s_stick_angular;
            in_stick_ang_pres_reg <= s_stick_angular_present;
            in_auto_lin_reg       <= s_auto_linear;
            in_auto_ang_reg       <= s_auto_angular;
            in_status_ok_reg      <= s_status_ok;
        end
        if (out_load) begin
            m_lin_reg   <= slew_lin_w[FIELD_W-1:0];
            m_ang_reg   <= slew_ang_w[FIELD_W-1:0];
            m_auto_reg  <= auto_flag_next;
            m_turbo_reg <= turbo_mode_next;
            m_stop_reg  <= stop_pending_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_linear_cmd    = m_lin_reg;
    assign m_angular_cmd   = m_ang_reg;
    assign m_auto_engaged  = m_auto_reg;
    assign m_turbo_engaged = m_turbo_reg;
    assign m_stop_active   = m_stop_reg;

    // ---------------- assertions ----------------
    a_pending_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_pending_reg |-> stop_armed_reg)
        else $error("stop pending without stop armed");

    a_auto_localized: assert property (@(posedge aclk) disable iff (!aresetn)
        auto_flag_reg |-> localized_flag_reg)
        else $error("auto mode while not localized");

    a_auto_resume_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(auto_flag_reg && resume_auto_reg))
        else $error("auto and resume-auto both set");

    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("tick processed without a result");

endmodule

// File: tb/drive_command_mode_and_slew_limiter_tb.sv
// Self-checking testbench for the drive command mode selector and slew limiter.
`timescale 1ns / 100ps

module drive_command_mode_and_slew_limiter_tb;
    import dcm_pkg::*;

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------
    // One event on the s_ channel, field for field.
    typedef struct packed {
        op_t                op;
        logic               gear;
        logic               enable;
        logic signed [15:0] stick_lin;
        logic               stick_lin_ok;
        logic signed [15:0] stick_ang;
        logic               stick_ang_ok;
        logic signed [15:0] req_lin;
        logic signed [15:0] req_ang;
        logic               localized_ok;
    } drive_event_t;

    // One command on the m_ channel.
    typedef struct packed {
        logic signed [15:0] lin;
        logic signed [15:0] ang;
        logic               auto_on;
        logic               turbo_on;
        logic               stop_on;
    } drive_cmd_t;

    // Directed row: the event, and a hand-written command where it is obvious.
    typedef struct packed {
        drive_event_t ev;
        logic         typed;
        drive_cmd_t   want;
    } drive_row_t;

    localparam cfg_t CFG_RESET = '{
        gain_linear_normal:  16'd4096,
        gain_linear_turbo:   16'd8192,
        gain_angular_normal: 16'd4096,
        gain_angular_turbo:  16'd8192,
        auto_linear_gain:    16'd4096,
        auto_angular_gain:   16'd4096,
        slew_step:           15'd41,
        zero_band:           15'd41
    };

    localparam int RANDOM_PER_PHASE = 170;
    localparam int NUM_PHASES       = 5;
    localparam int HOLD_CYCLES      = 120;  // long m_ready hold-off to back up the pipe
    localparam int PIPE_SETTLE      = 4;    // two-stage pipe plus margin
    localparam int QUIET_LIMIT      = 1000; // cycles with no transaction at all

    // ------------------------------------------------------------------
    // Clock, reset, DUT ports (every input known from time zero)
    // ------------------------------------------------------------------
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic               s_valid                 = 1'b0;
    logic               s_ready;
    logic [1:0]         s_operation             = '0;
    logic               s_gear_pressed          = 1'b0;
    logic               s_enable_pressed        = 1'b0;
    logic signed [15:0] s_stick_linear          = '0;
    logic               s_stick_linear_present  = 1'b0;
    logic signed [15:0] s_stick_angular         = '0;
    logic               s_stick_angular_present = 1'b0;
    logic signed [15:0] s_auto_linear           = '0;
    logic signed [15:0] s_auto_angular          = '0;
    logic               s_status_ok             = 1'b0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_linear_cmd;
    logic signed [15:0] m_angular_cmd;
    logic               m_auto_engaged;
    logic               m_turbo_engaged;
    logic               m_stop_active;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    drive_command_mode_and_slew_limiter dut (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_operation             (s_operation),
        .s_gear_pressed          (s_gear_pressed),
        .s_enable_pressed        (s_enable_pressed),
        .s_stick_linear          (s_stick_linear),
        .s_stick_linear_present  (s_stick_linear_present),
        .s_stick_angular         (s_stick_angular),
        .s_stick_angular_present (s_stick_angular_present),
        .s_auto_linear           (s_auto_linear),
        .s_auto_angular          (s_auto_angular),
        .s_status_ok             (s_status_ok),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_linear_cmd            (m_linear_cmd),
        .m_angular_cmd           (m_angular_cmd),
        .m_auto_engaged          (m_auto_engaged),
        .m_turbo_engaged         (m_turbo_engaged),
        .m_stop_active           (m_stop_active)
    );

    // ------------------------------------------------------------------
    // Predictor state: mirrors the block's registers after reset
    // ------------------------------------------------------------------
    cfg_t               regs           = CFG_RESET;
    logic               turbo_sel      = 1'b0;
    logic               gear_held      = 1'b0;
    logic               following_auto = 1'b0;
    logic               localized      = 1'b0;
    logic               stop_wait      = 1'b0;  // one-shot stop still pending
    logic               resume_pending = 1'b0;  // re-enter auto once localized again
    logic               stop_latched   = 1'b0;  // stop already armed for this loss
    logic signed [15:0] tgt_lin        = '0;
    logic signed [15:0] tgt_ang        = '0;
    logic signed [15:0] cmd_lin        = '0;
    logic signed [15:0] cmd_ang        = '0;

    drive_cmd_t pending_cmds[$];  // commands owed by the block, oldest first
    int         mismatches   = 0;
    int         quiet_cycles = 0;
    logic       no_gaps      = 1'b0;  // quiet stretch: neither side idles
    logic       hold_off_due = 1'b0;  // request for the long m_ready hold-off
    logic       hold_off_done = 1'b0; // receiver has served the hold-off

    // Saturate to the 16-bit velocity range.
    function automatic logic signed [15:0] clamp_vel(input longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Signed value times unsigned Q4.12 gain, floor shift, saturate.
    function automatic logic signed [15:0] scale_vel(input logic signed [15:0] x,
                                                     input logic [15:0] gain,
                                                     input int shift);
        longint prod;
        prod = longint'(x) * longint'({1'b0, gain});
        return clamp_vel(prod >>> shift);
    endfunction

    // One tick of slew limiting: full step, one limit, or two limits on a big jump.
    function automatic logic signed [15:0] slew_to(input logic signed [15:0] target,
                                                   input logic signed [15:0] last,
                                                   input logic [14:0] step);
        longint lim;
        longint d;
        longint r;
        lim = longint'({1'b0, step});
        d   = longint'(target) - longint'(last);
        r   = longint'(target);
        if (d > lim || d < -lim) begin
            if (d > 0)
                r = (d > 5 * lim) ? longint'(last) + 2 * lim : longint'(last) + lim;
            else
                r = (d < -5 * lim) ? longint'(last) - 2 * lim : longint'(last) - lim;
        end
        return clamp_vel(r);
    endfunction

    // Advance the predicted state by one accepted event; ticks yield a command.
    task automatic drive_update(input drive_event_t ev, output logic made,
                                output drive_cmd_t cmd);
        longint zb;
        made = 1'b0;
        cmd  = '0;
        case (ev.op)
            OP_JOY: begin
                // gear toggles on the press edge only
                if (ev.gear && !gear_held) begin
                    turbo_sel = !turbo_sel;
                    gear_held = 1'b1;
                end else if (!ev.gear && gear_held) begin
                    gear_held = 1'b0;
                end
                if (!ev.enable || !localized) begin
                    following_auto = 1'b0;
                    tgt_lin = ev.stick_lin_ok ? scale_vel(ev.stick_lin,
                        turbo_sel ? regs.gain_linear_turbo : regs.gain_linear_normal, 15) : '0;
                    tgt_ang = ev.stick_ang_ok ? scale_vel(ev.stick_ang,
                        turbo_sel ? regs.gain_angular_turbo : regs.gain_angular_normal, 15) : '0;
                end else begin
                    following_auto = 1'b1;
                end
            end
            OP_AUTO: begin
                if (following_auto) begin
                    tgt_lin = scale_vel(ev.req_lin, regs.auto_linear_gain, 12);
                    tgt_ang = scale_vel(ev.req_ang, regs.auto_angular_gain, 12);
                end
            end
            OP_STATUS: begin
                if (ev.localized_ok) begin
                    localized    = 1'b1;
                    stop_wait    = 1'b0;
                    stop_latched = 1'b0;
                    if (resume_pending) begin
                        following_auto = 1'b1;
                        resume_pending = 1'b0;
                    end
                end else begin
                    localized = 1'b0;
                    if (following_auto) begin
                        tgt_lin        = '0;
                        tgt_ang        = '0;
                        resume_pending = 1'b1;
                    end
                    following_auto = 1'b0;
                    if (!stop_latched) begin
                        stop_wait    = 1'b1;
                        stop_latched = 1'b1;
                    end
                end
            end
            default: begin
                zb = longint'({1'b0, regs.zero_band});
                // stop releases once both targets sit strictly inside the zero band
                if (stop_wait && longint'(tgt_lin) < zb && longint'(tgt_lin) > -zb &&
                    longint'(tgt_ang) < zb && longint'(tgt_ang) > -zb) begin
                    stop_wait = 1'b0;
                end else if (stop_wait) begin
                    tgt_lin = '0;
                    tgt_ang = '0;
                end
                cmd_lin = slew_to(tgt_lin, cmd_lin, regs.slew_step);
                cmd_ang = slew_to(tgt_ang, cmd_ang, regs.slew_step);
                made    = 1'b1;
                cmd     = '{cmd_lin, cmd_ang, following_auto, turbo_sel, stop_wait};
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Event builders for the directed table
    // ------------------------------------------------------------------
    function automatic drive_event_t mk_joy(input logic gear, input logic enable,
                                            input logic signed [15:0] lin, input logic lin_ok,
                                            input logic signed [15:0] ang, input logic ang_ok);
        drive_event_t ev;
        ev              = '0;
        ev.op           = OP_JOY;
        ev.gear         = gear;
        ev.enable       = enable;
        ev.stick_lin    = lin;
        ev.stick_lin_ok = lin_ok;
        ev.stick_ang    = ang;
        ev.stick_ang_ok = ang_ok;
        return ev;
    endfunction

    function automatic drive_event_t mk_req(input logic signed [15:0] lin,
                                            input logic signed [15:0] ang);
        drive_event_t ev;
        ev         = '0;
        ev.op      = OP_AUTO;
        ev.req_lin = lin;
        ev.req_ang = ang;
        return ev;
    endfunction

    function automatic drive_event_t mk_status(input logic ok);
        drive_event_t ev;
        ev              = '0;
        ev.op           = OP_STATUS;
        ev.localized_ok = ok;
        return ev;
    endfunction

    function automatic drive_event_t mk_tick();
        drive_event_t ev;
        ev    = '0;
        ev.op = OP_TICK;
        return ev;
    endfunction

    // Velocity values weighted toward the extremes and zero.
    function automatic logic signed [15:0] pick_velocity();
        int          v;
        logic [31:0] w;
        case ($urandom_range(7))
            0:       w = 32'h0000_7FFF;
            1:       w = 32'h0000_8000;
            2:       w = '0;
            3: begin
                v = int'($urandom_range(256)) - 128;
                w = v;
            end
            default: w = $urandom;
        endcase
        return w[15:0];
    endfunction

    // Random event: mostly joystick and ticks, enough status traffic to
    // walk through loss/recovery, and every field filled even when unused.
    function automatic drive_event_t random_event();
        drive_event_t ev;
        int           pick;
        pick = $urandom_range(99);
        if (pick < 30)      ev.op = OP_JOY;
        else if (pick < 48) ev.op = OP_AUTO;
        else if (pick < 60) ev.op = OP_STATUS;
        else                ev.op = OP_TICK;
        ev.gear         = 1'($urandom_range(1));
        ev.enable       = ($urandom_range(99) < 60);
        ev.stick_lin    = pick_velocity();
        ev.stick_lin_ok = ($urandom_range(99) < 85);
        ev.stick_ang    = pick_velocity();
        ev.stick_ang_ok = ($urandom_range(99) < 85);
        ev.req_lin      = pick_velocity();
        ev.req_ang      = pick_velocity();
        ev.localized_ok = ($urandom_range(99) < 70);
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offer one event and hold it until the block takes it. Called on a rising
    // edge; valid is left high so back-to-back transactions need no re-assert.
    task automatic send_event(input drive_event_t ev, input logic typed,
                              input drive_cmd_t want);
        logic       made;
        drive_cmd_t cmd;
        s_valid                 <= 1'b1;
        s_operation             <= ev.op;
        s_gear_pressed          <= ev.gear;
        s_enable_pressed        <= ev.enable;
        s_stick_linear          <= ev.stick_lin;
        s_stick_linear_present  <= ev.stick_lin_ok;
        s_stick_angular         <= ev.stick_ang;
        s_stick_angular_present <= ev.stick_ang_ok;
        s_auto_linear           <= ev.req_lin;
        s_auto_angular          <= ev.req_ang;
        s_status_ok             <= ev.localized_ok;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        drive_update(ev, made, cmd);
        if (made) pending_cmds.push_back(typed ? want : cmd);
    endtask

    // Random sender gap after about 7 events in a hundred, unless no_gaps is set.
    task automatic maybe_gap();
        if (!no_gaps && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // Stop sending, wait for every owed command, then let non-tick events
    // still in the pipe drain out.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    // APB write: setup then access. psel is left up so writes can run back to
    // back; the caller drops it after the last one.
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value,
                             input logic junk);
        logic [31:0] mask;
        logic [31:0] word;
        mask = (idx == REG_SLEW_STEP || idx == REG_ZERO_BAND) ? 32'h0000_7FFF : 32'h0000_FFFF;
        word = value & mask;
        if (junk) word = word | ($urandom & ~mask);  // upper bits must be ignored
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_GAIN_LIN_NORMAL: regs.gain_linear_normal  = word[15:0];
            REG_GAIN_LIN_TURBO:  regs.gain_linear_turbo   = word[15:0];
            REG_GAIN_ANG_NORMAL: regs.gain_angular_normal = word[15:0];
            REG_GAIN_ANG_TURBO:  regs.gain_angular_turbo  = word[15:0];
            REG_AUTO_LIN_GAIN:   regs.auto_linear_gain    = word[15:0];
            REG_AUTO_ANG_GAIN:   regs.auto_angular_gain   = word[15:0];
            REG_SLEW_STEP:       regs.slew_step           = word[14:0];
            default:             regs.zero_band           = word[14:0];
        endcase
    endtask

    task automatic load_settings(input cfg_t c, input logic junk);
        write_reg(REG_GAIN_LIN_NORMAL, {16'h0, c.gain_linear_normal}, junk);
        write_reg(REG_GAIN_LIN_TURBO,  {16'h0, c.gain_linear_turbo}, junk);
        write_reg(REG_GAIN_ANG_NORMAL, {16'h0, c.gain_angular_normal}, junk);
        write_reg(REG_GAIN_ANG_TURBO,  {16'h0, c.gain_angular_turbo}, junk);
        write_reg(REG_AUTO_LIN_GAIN,   {16'h0, c.auto_linear_gain}, junk);
        write_reg(REG_AUTO_ANG_GAIN,   {16'h0, c.auto_angular_gain}, junk);
        write_reg(REG_SLEW_STEP,       {17'h0, c.slew_step}, junk);
        write_reg(REG_ZERO_BAND,       {17'h0, c.zero_band}, junk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, a quiet stretch, and one long hold-off
    // ------------------------------------------------------------------
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_off_due && !hold_off_done) begin
                // sender keeps offering; ticks back up and s_ready must drop
                hold_off_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= no_gaps || ($urandom_range(99) >= 7);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every command transaction against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        drive_cmd_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                $error("command transaction with none predicted: lin %0d ang %0d",
                       m_linear_cmd, m_angular_cmd);
                mismatches++;
            end else begin
                want = pending_cmds.pop_front();
                check_field("linear_cmd", $signed(want.lin), m_linear_cmd);
                check_field("angular_cmd", $signed(want.ang), m_angular_cmd);
                check_field("auto_engaged", want.auto_on, m_auto_engaged);
                check_field("turbo_engaged", want.turbo_on, m_turbo_engaged);
                check_field("stop_active", want.stop_on, m_stop_active);
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("** drive_command_mode_and_slew_limiter: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    drive_row_t directed_rows[$];

    initial begin
        cfg_t c;
        logic junk;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass at reset settings (gain 1.0 normal, 2.0 turbo, L = 41).
        // tick straight out of reset: everything at rest
        directed_rows.push_back('{mk_tick(), 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}});
        // full-scale sticks, then a big jump limited to two steps (2L = 82)
        directed_rows.push_back('{mk_joy(1'b0, 1'b0, 16'sh7FFF, 1'b1, 16'sh8000, 1'b1),
                                  1'b0, '0});
        directed_rows.push_back('{mk_tick(), 1'b1, '{16'sd82, -16'sd82, 1'b0, 1'b0, 1'b0}});
        // gear press edge toggles turbo; holding it does not toggle again
        directed_rows.push_back('{mk_joy(1'b1, 1'b0, 16'sh7FFF, 1'b1, 16'sd0, 1'b0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_joy(1'b1, 1'b0, 16'sd0, 1'b0, 16'sd0, 1'b0), 1'b0, '0});
        directed_rows.push_back('{mk_tick(), 1'b0, '0});
        // release; -1 rounds toward minus infinity, +1 rounds to zero
        directed_rows.push_back('{mk_joy(1'b0, 1'b0, -16'sd1, 1'b1, 16'sd1, 1'b1), 1'b0, '0});
        directed_rows.push_back('{mk_tick(), 1'b0, '0});
        // localization loss while manual arms the one-shot stop
        directed_rows.push_back('{mk_status(1'b0), 1'b0, '0});
        // enable while not localized stays manual
        directed_rows.push_back('{mk_joy(1'b0, 1'b1, 16'sh8000, 1'b1, 16'sh7FFF, 1'b1),
                                  1'b0, '0});
        directed_rows.push_back('{mk_tick(), 1'b0, '0});  // stop zeroes targets
        directed_rows.push_back('{mk_tick(), 1'b0, '0});  // targets in band: stop clears
        directed_rows.push_back('{mk_status(1'b0), 1'b0, '0});  // already armed: no re-stop
        directed_rows.push_back('{mk_status(1'b1), 1'b0, '0});
        // enable while localized engages auto, then full-scale requests
        directed_rows.push_back('{mk_joy(1'b0, 1'b1, 16'sd0, 1'b1, 16'sd0, 1'b1), 1'b0, '0});
        directed_rows.push_back('{mk_req(16'sh7FFF, 16'sh8000), 1'b0, '0});
        directed_rows.push_back('{mk_tick(), 1'b0, '0});
        // loss while auto: targets zeroed, auto remembered for later
        directed_rows.push_back('{mk_status(1'b0), 1'b0, '0});
        directed_rows.push_back('{mk_req(16'sd100, 16'sd100), 1'b0, '0});  // ignored in manual
        directed_rows.push_back('{mk_tick(), 1'b0, '0});
        directed_rows.push_back('{mk_status(1'b1), 1'b0, '0});  // auto resumes
        directed_rows.push_back('{mk_tick(), 1'b0, '0});
        directed_rows.push_back('{mk_req(-16'sd1, 16'sd1), 1'b0, '0});
        directed_rows.push_back('{mk_joy(1'b1, 1'b0, 16'sd0, 1'b0, 16'sd0, 1'b0), 1'b0, '0});
        directed_rows.push_back('{mk_tick(), 1'b0, '0});

        foreach (directed_rows[i]) begin
            send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
            maybe_gap();
        end

        // Random phases, each under its own register setting:
        //   0 random values, with the long receiver hold-off partway through
        //   1 all maxima, no idling on either side
        //   2 all zero (slew never moves, zero band never releases a stop)
        //   3 tiny slew step, wide zero band
        //   4 back to reset values
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            junk = 1'b0;
            case (phase)
                0: begin
                    c.gain_linear_normal  = 16'($urandom_range(65535));
                    c.gain_linear_turbo   = 16'($urandom_range(65535));
                    c.gain_angular_normal = 16'($urandom_range(65535));
                    c.gain_angular_turbo  = 16'($urandom_range(65535));
                    c.auto_linear_gain    = 16'($urandom_range(65535));
                    c.auto_angular_gain   = 16'($urandom_range(65535));
                    c.slew_step           = 15'($urandom_range(600));
                    c.zero_band           = 15'($urandom_range(600));
                    junk                  = 1'b1;
                end
                1: begin
                    c = '1;
                end
                2: begin
                    c = '0;
                end
                3: begin
                    c.gain_linear_normal  = 16'($urandom_range(65535));
                    c.gain_linear_turbo   = 16'($urandom_range(65535));
                    c.gain_angular_normal = 16'($urandom_range(65535));
                    c.gain_angular_turbo  = 16'($urandom_range(65535));
                    c.auto_linear_gain    = 16'($urandom_range(65535));
                    c.auto_angular_gain   = 16'($urandom_range(65535));
                    c.slew_step           = 15'($urandom_range(1, 16));
                    c.zero_band           = 15'($urandom_range(3000));
                    junk                  = 1'b1;
                end
                default: begin
                    c = CFG_RESET;
                end
            endcase
            load_settings(c, junk);
            no_gaps = (phase == 1);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (phase == 0 && n == 60) hold_off_due = 1'b1;
                send_event(random_event(), 1'b0, '0);
                maybe_gap();
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("** drive_command_mode_and_slew_limiter: PASSED **");
        end else begin
            $display("** drive_command_mode_and_slew_limiter: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/dcm_pkg.sv
rtl/dcm_cfg_regs.sv
rtl/dcm_scale.sv
rtl/dcm_slew.sv
rtl/drive_command_mode_and_slew_limiter.sv
tb/drive_command_mode_and_slew_limiter_tb.sv
